FILE: sv/sreqt_pkg.sv
package sreqt_pkg;

   localparam logic [1:0] OUTCOME_UPDATED  = 2'd0;
   localparam logic [1:0] OUTCOME_INSERTED = 2'd1;
   localparam logic [1:0] OUTCOME_DROPPED  = 2'd2;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [31:0] source_address;
      logic [31:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic [1:0]  outcome;
      logic [3:0]  entry_index;
      logic [31:0] count_after;
      logic [4:0]  entries_used;
   } rsp_type;

   typedef struct packed {
      logic [31:0] address;
      logic [31:0] count;
      logic [31:0] last_seen;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_COMPARE,
      ST_FINISH
   } state_type;

endpackage

FILE: sv/sreqt_mem.sv
module sreqt_mem #(
   parameter int DEPTH = 16,
   parameter int IW    = 4
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [IW-1:0]         rd_addr,
   output sreqt_pkg::entry_type  rd_data,
   input  logic                  wr_en,
   input  logic [IW-1:0]         wr_addr,
   input  sreqt_pkg::entry_type  wr_data
);

   sreqt_pkg::entry_type entry_mem_ff [DEPTH];
   sreqt_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/sreqt_ctrl.sv
module sreqt_ctrl #(
   parameter int DEPTH = 16,
   parameter int IW    = 4,
   parameter int CW    = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sreqt_pkg::req_type    req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sreqt_pkg::rsp_type    rsp_data,
   output logic                  mem_rd_en,
   output logic [IW-1:0]         mem_rd_addr,
   input  sreqt_pkg::entry_type  mem_rd_data,
   output logic                  mem_wr_en,
   output logic [IW-1:0]         mem_wr_addr,
   output sreqt_pkg::entry_type  mem_wr_data
);

   localparam int XW = (CW > 5) ? CW : 5;

   sreqt_pkg::state_type state_ff, state_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        used_ff, used_in;
   sreqt_pkg::req_type   item_ff, item_in;
   logic [31:0]          count_ff, count_in;
   logic [1:0]           outcome_ff, outcome_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   sreqt_pkg::rsp_type   rsp_ff, rsp_in;

   logic                 req_take;
   logic                 at_end;
   logic                 full;
   logic                 hit;
   logic                 emit;
   logic [XW-1:0]        idx_ext;
   logic [XW-1:0]        used_ext;

   assign req_take = req_valid && !req_stall;
   assign at_end   = (idx_ff == used_ff);
   assign full     = (used_ff == CW'(DEPTH));
   assign hit      = (mem_rd_data.address == item_ff.source_address);
   assign emit     = (state_ff == sreqt_pkg::ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sreqt_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = sreqt_pkg::ST_LOOKUP;
            end
         end
         sreqt_pkg::ST_LOOKUP: begin
            state_in = at_end ? sreqt_pkg::ST_FINISH : sreqt_pkg::ST_COMPARE;
         end
         sreqt_pkg::ST_COMPARE: begin
            state_in = hit ? sreqt_pkg::ST_FINISH : sreqt_pkg::ST_LOOKUP;
         end
         sreqt_pkg::ST_FINISH: begin
            if (emit) begin
               state_in = sreqt_pkg::ST_IDLE;
            end
         end
         default: state_in = sreqt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      idx_in       = idx_ff;
      used_in      = used_ff;
      item_in      = item_ff;
      count_in     = count_ff;
      outcome_in   = outcome_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      req_stall    = (state_ff != sreqt_pkg::ST_IDLE);
      mem_rd_en    = 1'b0;
      mem_wr_en    = 1'b0;
      used_ext     = '0;
      idx_ext      = XW'(idx_ff);
      case (state_ff)
         sreqt_pkg::ST_IDLE: begin
            if (req_take) begin
               item_in = req_data;
               idx_in  = '0;
            end
         end
         sreqt_pkg::ST_LOOKUP: begin
            if (at_end) begin
               if (full) begin
                  outcome_in = sreqt_pkg::OUTCOME_DROPPED;
                  count_in   = '0;
               end else begin
                  outcome_in = sreqt_pkg::OUTCOME_INSERTED;
                  count_in   = 32'd1;
               end
            end else begin
               mem_rd_en = 1'b1;
            end
         end
         sreqt_pkg::ST_COMPARE: begin
            if (hit) begin
               outcome_in = sreqt_pkg::OUTCOME_UPDATED;
               count_in   = (mem_rd_data.count == sreqt_pkg::COUNT_MAX) ?
                            mem_rd_data.count : mem_rd_data.count + 32'd1;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         sreqt_pkg::ST_FINISH: begin
            if (emit) begin
               mem_wr_en = (outcome_ff != sreqt_pkg::OUTCOME_DROPPED);
               if (outcome_ff == sreqt_pkg::OUTCOME_INSERTED) begin
                  used_in = used_ff + CW'(1);
               end
               used_ext             = XW'(used_in);
               rsp_valid_in         = 1'b1;
               rsp_in.outcome       = outcome_ff;
               rsp_in.entry_index   = (outcome_ff == sreqt_pkg::OUTCOME_DROPPED) ?
                                      4'd0 : idx_ext[3:0];
               rsp_in.count_after   = count_ff;
               rsp_in.entries_used  = used_ext[4:0];
            end
         end
         default: begin
         end
      endcase
   end

   assign mem_rd_addr           = idx_ff[IW-1:0];
   assign mem_wr_addr           = idx_ff[IW-1:0];
   assign mem_wr_data.address   = item_ff.source_address;
   assign mem_wr_data.count     = count_ff;
   assign mem_wr_data.last_seen = item_ff.now_seconds;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sreqt_pkg::ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      item_ff    <= item_in;
      count_ff   <= count_in;
      outcome_ff <= outcome_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: sv/source_request_tracking_table.sv
// Channel  | Ports                          | Direction | Transaction
// request  | req_valid req_stall req_data   | in        | source address, time
// response | rsp_valid rsp_stall rsp_data   | out       | outcome, index, count, used
//
// One transaction at a time. Per accepted request, a hit at entry j reads
// entries 0 to j, and a miss with u entries in use reads all u, at most
// TABLE_DEPTH. Each compare is one entry memory read in ST_LOOKUP plus a check in ST_COMPARE.
// Valid entries always form a prefix, so a fill count replaces valid bits and
// reset needs no clearing pass. A new request is taken while a response waits;
// a stalled response holds the sequencer in ST_FINISH until it leaves.
module source_request_tracking_table #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sreqt_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sreqt_pkg::rsp_type  rsp_data
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic                 mem_rd_en;
   logic [IW-1:0]        mem_rd_addr;
   sreqt_pkg::entry_type mem_rd_data;
   logic                 mem_wr_en;
   logic [IW-1:0]        mem_wr_addr;
   sreqt_pkg::entry_type mem_wr_data;

   sreqt_ctrl #(
      .DEPTH (TABLE_DEPTH),
      .IW    (IW),
      .CW    (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   sreqt_mem #(
      .DEPTH (TABLE_DEPTH),
      .IW    (IW)
   ) u_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

endmodule

FILE: sv/sreqt_check.sv
module sreqt_check (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input sreqt_pkg::rsp_type  rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.outcome == sreqt_pkg::OUTCOME_DROPPED |->
         rsp_data.entry_index == 4'd0 && rsp_data.count_after == 32'd0)
      else $error("dropped transaction with nonzero index or count");

   a_insert_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.outcome == sreqt_pkg::OUTCOME_INSERTED |->
         rsp_data.count_after == 32'd1)
      else $error("insert without count of one");

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while a transaction is in progress");

endmodule

bind source_request_tracking_table sreqt_check u_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
